// ===== src/crte_pkg.sv =====
// Shared types, codes and constants for the clock reply to epoch block.
// Used by crte_ctrl, crte_dp and the top level clock_reply_to_epoch.
package crte_pkg;

	localparam int REPLY_BYTES_DEF = 47;
	localparam int CNT_W           = 8;
	localparam int FIELDS          = 7;
	localparam int FIELD_W         = 16;
	localparam int ACC_W           = 16;
	localparam int ACC_MUL_W       = 19;
	localparam int DEC_BASE        = 10;
	localparam int ACC_SAT         = 32768;
	localparam int FIELD_MAX       = 32767;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// date conversion constants
	localparam int YEAR_BASE  = 2000;
	localparam int YEAR_MIN   = 20;
	localparam int MON_SPLIT  = 2;
	localparam int MON_ADJ_LO = 9;
	localparam int MON_ADJ_HI = 3;
	localparam int DOY_MUL    = 153;
	localparam int DOY_ADD    = 2;
	localparam int ERA_YEARS  = 400;
	localparam int DAYS_YEAR  = 365;
	localparam int DAYS_ERA   = 146097;
	localparam int DAYS_SHIFT = 719468;
	localparam int SEC_DAY    = 86400;
	localparam int SEC_HOUR   = 3600;
	localparam int SEC_MIN    = 60;
	localparam int SEC_TZ     = 900;

	// reciprocals for division by constants: q = (x * RECIP) >> K
	localparam int RECIP_400 = 41944;
	localparam int K_400     = 24;
	localparam int RECIP_5   = 6710887;
	localparam int K_5       = 25;
	localparam int RECIP_100 = 656;
	localparam int K_100     = 16;

	typedef enum logic [4:0] {
		PH_SEARCH = 5'b00001,
		PH_START  = 5'b00010,
		PH_SIGN   = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_STOP   = 5'b10000
	} phase_t;

	typedef enum logic [3:0] {
		CS_IDLE = 4'b0001,
		CS_FIN  = 4'b0010,
		CS_CONV = 4'b0100,
		CS_LOAD = 4'b1000
	} ctrl_state_t;

	typedef enum logic [3:0] {
		ST_YM     = 4'd0,
		ST_NUM    = 4'd1,
		ST_ERA    = 4'd2,
		ST_Q5     = 4'd3,
		ST_DOY    = 4'd4,
		ST_C100   = 4'd5,
		ST_DOE    = 4'd6,
		ST_ERADAY = 4'd7,
		ST_DAYS   = 4'd8,
		ST_SEC_D  = 4'd9,
		ST_SEC_H  = 4'd10,
		ST_SEC_M  = 4'd11,
		ST_SEC_S  = 4'd12
	} step_t;

	typedef struct packed {
		logic  apply_byte;
		logic  finish;
		logic  conv;
		step_t step;
		logic  load;
	} cmd_t;

	typedef struct packed {
		logic field_open;
		logic fields_ok;
	} status_t;

	// literal expected after field idx
	function automatic logic [7:0] sep_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0, 3'd1: ch = CH_SLASH;
			3'd2:       ch = CH_COMMA;
			3'd3, 3'd4: ch = CH_COLON;
			default:    ch = CH_PLUS;
		endcase
		return ch;
	endfunction

endpackage

// ===== src/clock_reply_to_epoch.sv =====
// Top level of the clock reply to epoch block: joins controller and datapath.
// Depends on crte_pkg, crte_ctrl and crte_dp.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+--------------------------------
//  byte in  | byte_valid / byte_stall    | reply_byte[7:0], last_byte
//  result   | result_valid / result_stall| time_ok, epoch_seconds[31:0]
//
// A byte is accepted while byte_valid is high and byte_stall is low. After
// the byte marked last the input stalls while the sequencer runs the date
// conversion, at most one multiply per step, or skips it for a reply that
// did not parse, and while result_stall holds the output register. Reset
// clears the parser and the output valid flag; there is no clearing pass.
module clock_reply_to_epoch #(
	parameter int REPLY_BYTES = crte_pkg::REPLY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  reply_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        time_ok,
	output logic [31:0] epoch_seconds
);

	crte_pkg::cmd_t    cmd;
	crte_pkg::status_t status;

	crte_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.last_byte    (last_byte),
		.byte_stall   (byte_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	crte_dp #(
		.REPLY_BYTES (REPLY_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.reply_byte    (reply_byte),
		.cmd           (cmd),
		.status        (status),
		.time_ok       (time_ok),
		.epoch_seconds (epoch_seconds)
	);

endmodule

// ===== src/crte_ctrl.sv =====
// Controller for the clock reply to epoch block: byte intake, conversion
// step sequencing and output register handshake. Depends on crte_pkg.
module crte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               last_byte,
	output logic               byte_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  crte_pkg::status_t  status,
	output crte_pkg::cmd_t     cmd
);

	crte_pkg::ctrl_state_t state_q, state_d;
	crte_pkg::step_t       step_q, step_d;
	logic                  valid_q, valid_d;
	logic                  out_free;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		out_free = !valid_q || !result_stall;
		case (state_q)
			crte_pkg::CS_IDLE: begin
				if (byte_valid) begin
					cmd.apply_byte = 1'b1;
					if (last_byte) begin
						state_d = crte_pkg::CS_FIN;
					end
				end
			end
			crte_pkg::CS_FIN: begin
				cmd.finish = status.field_open;
				step_d     = crte_pkg::ST_YM;
				state_d    = crte_pkg::CS_CONV;
			end
			crte_pkg::CS_CONV: begin
				// skip the arithmetic when the reply did not parse
				if (!status.fields_ok) begin
					state_d = crte_pkg::CS_LOAD;
				end else begin
					cmd.conv = 1'b1;
					cmd.step = step_q;
					if (step_q == crte_pkg::ST_SEC_S) begin
						state_d = crte_pkg::CS_LOAD;
					end else begin
						step_d = crte_pkg::step_t'(step_q + 4'd1);
					end
				end
			end
			crte_pkg::CS_LOAD: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = crte_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = crte_pkg::CS_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.load) begin
			valid_d = 1'b1;
		end else if (!result_stall) begin
			valid_d = 1'b0;
		end else begin
			valid_d = valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crte_pkg::CS_IDLE;
			step_q  <= crte_pkg::ST_YM;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			valid_q <= valid_d;
		end
	end

	assign byte_stall   = (state_q != crte_pkg::CS_IDLE);
	assign result_valid = valid_q;

endmodule

// ===== src/crte_dp.sv =====
// Datapath for the clock reply to epoch block: field parser, date
// arithmetic registers and output register. Depends on crte_pkg.
module crte_dp #(
	parameter int REPLY_BYTES = crte_pkg::REPLY_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         reply_byte,
	input  crte_pkg::cmd_t     cmd,
	output crte_pkg::status_t  status,
	output logic               time_ok,
	output logic [31:0]        epoch_seconds
);

	// parser state
	crte_pkg::phase_t                   phase_q, phase_d;
	logic [crte_pkg::ACC_W-1:0]         acc_q, acc_d;
	logic                               neg_q, neg_d;
	logic [crte_pkg::FIELD_W-1:0]       fields_q [crte_pkg::FIELDS];
	logic [2:0]                         fcnt_q;
	logic [crte_pkg::CNT_W-1:0]         bytes_q;
	logic                               ended_q;

	logic                               counted;
	logic                               is_digit;
	logic                               is_blank;
	logic [3:0]                         digit;
	logic [crte_pkg::ACC_MUL_W-1:0]     acc_mul;
	logic [crte_pkg::ACC_W-1:0]         acc_step;
	logic                               close_byte;
	logic                               do_close;
	logic [crte_pkg::FIELD_W-1:0]       close_val;
	logic                               fields_ok;

	// conversion registers
	logic [15:0]        y_q;
	logic signed [16:0] mp_q;
	logic               nneg_q;
	logic [23:0]        nmag_q;
	logic [6:0]         era_q;
	logic [19:0]        q5_q;
	logic [8:0]         yoe_q;
	logic signed [21:0] doy_q;
	logic [1:0]         c100_q;
	logic signed [22:0] doe_q;
	logic [23:0]        eraday_q;
	logic [31:0]        days_q;
	logic [31:0]        sec_q;
	logic               ok_q;
	logic [31:0]        epoch_q;

	logic signed [15:0] f_mon;
	logic               mon_low;
	logic [15:0]        y_next;
	logic signed [16:0] mp_next;
	logic signed [24:0] num;
	logic [23:0]        nmag_next;
	logic [31:0]        era_prod;
	logic [47:0]        q5_prod;
	logic signed [21:0] q5_s;
	logic [19:0]        c100_prod;
	logic [17:0]        yday;
	logic [31:0]        tz_sec;

	// byte parsing
	always_comb begin
		is_digit   = reply_byte inside {[crte_pkg::CH_ZERO:crte_pkg::CH_NINE]};
		is_blank   = reply_byte inside {crte_pkg::CH_SPACE,
			[crte_pkg::CH_TAB:crte_pkg::CH_CR]};
		digit      = 4'(reply_byte - crte_pkg::CH_ZERO);
		counted    = cmd.apply_byte && !ended_q &&
			(bytes_q < crte_pkg::CNT_W'(REPLY_BYTES));
		acc_mul    = crte_pkg::ACC_MUL_W'(acc_q) * crte_pkg::ACC_MUL_W'(crte_pkg::DEC_BASE)
			+ crte_pkg::ACC_MUL_W'(digit);
		acc_step   = (acc_mul > crte_pkg::ACC_MUL_W'(crte_pkg::ACC_SAT)) ?
			crte_pkg::ACC_W'(crte_pkg::ACC_SAT) : acc_mul[crte_pkg::ACC_W-1:0];
		phase_d    = phase_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		close_byte = 1'b0;
		if (counted && (reply_byte != crte_pkg::CH_NUL)) begin
			case (phase_q)
				crte_pkg::PH_SEARCH: begin
					if (reply_byte == crte_pkg::CH_QUOTE) begin
						phase_d = crte_pkg::PH_START;
					end
				end
				crte_pkg::PH_START: begin
					if (is_blank) begin
						phase_d = crte_pkg::PH_START;
					end else if (reply_byte inside {crte_pkg::CH_PLUS, crte_pkg::CH_MINUS}) begin
						neg_d   = (reply_byte == crte_pkg::CH_MINUS);
						phase_d = crte_pkg::PH_SIGN;
					end else if (is_digit) begin
						acc_d   = crte_pkg::ACC_W'(digit);
						phase_d = crte_pkg::PH_DIGITS;
					end else begin
						phase_d = crte_pkg::PH_STOP;
					end
				end
				crte_pkg::PH_SIGN: begin
					if (is_digit) begin
						acc_d   = crte_pkg::ACC_W'(digit);
						phase_d = crte_pkg::PH_DIGITS;
					end else begin
						phase_d = crte_pkg::PH_STOP;
					end
				end
				crte_pkg::PH_DIGITS: begin
					if (is_digit) begin
						acc_d = acc_step;
					end else begin
						close_byte = 1'b1;
						// stop after the last field or on a wrong separator
						if (fcnt_q == 3'(crte_pkg::FIELDS - 1)) begin
							phase_d = crte_pkg::PH_STOP;
						end else if (reply_byte == crte_pkg::sep_char(fcnt_q)) begin
							phase_d = crte_pkg::PH_START;
						end else begin
							phase_d = crte_pkg::PH_STOP;
						end
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
		do_close = close_byte || cmd.finish;
		if (do_close) begin
			acc_d = '0;
			neg_d = 1'b0;
		end
		// negate or clamp the magnitude into 16 bits
		if (neg_q) begin
			close_val = ~acc_q + 1'b1;
		end else if (acc_q[crte_pkg::ACC_W-1]) begin
			close_val = crte_pkg::FIELD_W'(crte_pkg::FIELD_MAX);
		end else begin
			close_val = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crte_pkg::PH_SEARCH;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			fcnt_q  <= '0;
			bytes_q <= '0;
			ended_q <= 1'b0;
		end else if (cmd.load) begin
			phase_q <= crte_pkg::PH_SEARCH;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			fcnt_q  <= '0;
			bytes_q <= '0;
			ended_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			if (counted) begin
				bytes_q <= bytes_q + 1'b1;
				if (reply_byte == crte_pkg::CH_NUL) begin
					ended_q <= 1'b1;
				end
			end
			if (do_close && (fcnt_q < 3'(crte_pkg::FIELDS))) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_close && (fcnt_q < 3'(crte_pkg::FIELDS))) begin
			fields_q[fcnt_q] <= close_val;
		end
	end

	assign fields_ok = (fcnt_q >= 3'(crte_pkg::FIELDS - 1)) &&
		($signed(fields_q[0]) >= $signed(16'(crte_pkg::YEAR_MIN)));

	// date arithmetic, at most one multiply per step
	always_comb begin
		f_mon     = $signed(fields_q[1]);
		mon_low   = f_mon <= $signed(16'(crte_pkg::MON_SPLIT));
		y_next    = 16'(crte_pkg::YEAR_BASE) + fields_q[0] - {15'd0, mon_low};
		mp_next   = 17'(f_mon) + (mon_low ? 17'(crte_pkg::MON_ADJ_LO)
			: -17'(crte_pkg::MON_ADJ_HI));
		num       = 25'(mp_q) * 25'(crte_pkg::DOY_MUL) + 25'(crte_pkg::DOY_ADD);
		nmag_next = num[24] ? 24'(-num) : 24'(num);
		era_prod  = 32'(y_q) * 32'(crte_pkg::RECIP_400);
		q5_prod   = 48'(nmag_q) * 48'(crte_pkg::RECIP_5);
		q5_s      = $signed({2'b00, q5_q});
		c100_prod = 20'(yoe_q) * 20'(crte_pkg::RECIP_100);
		yday      = 18'(18'(yoe_q) * 18'(crte_pkg::DAYS_YEAR)) + 18'(yoe_q >> 2)
			- 18'(c100_q);
		// tz counts only when a seventh field parsed
		tz_sec    = (fcnt_q == 3'(crte_pkg::FIELDS)) ?
			32'(32'($signed(fields_q[6])) * 32'(crte_pkg::SEC_TZ)) : 32'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.conv) begin
			case (cmd.step)
				crte_pkg::ST_YM: begin
					y_q  <= y_next;
					mp_q <= mp_next;
				end
				crte_pkg::ST_NUM: begin
					nneg_q <= num[24];
					nmag_q <= nmag_next;
				end
				crte_pkg::ST_ERA: begin
					era_q <= 7'(era_prod >> crte_pkg::K_400);
				end
				crte_pkg::ST_Q5: begin
					q5_q <= 20'(q5_prod >> crte_pkg::K_5);
				end
				crte_pkg::ST_DOY: begin
					yoe_q <= 9'(y_q - 16'(16'(era_q) * 16'(crte_pkg::ERA_YEARS)));
					doy_q <= (nneg_q ? -q5_s : q5_s) + 22'($signed(fields_q[2])) - 22'sd1;
				end
				crte_pkg::ST_C100: begin
					c100_q <= 2'(c100_prod >> crte_pkg::K_100);
				end
				crte_pkg::ST_DOE: begin
					doe_q <= $signed({5'd0, yday}) + doy_q;
				end
				crte_pkg::ST_ERADAY: begin
					eraday_q <= 24'(24'(era_q) * 24'(crte_pkg::DAYS_ERA));
				end
				crte_pkg::ST_DAYS: begin
					days_q <= 32'({8'd0, eraday_q}) + 32'(doe_q)
						- 32'(crte_pkg::DAYS_SHIFT);
				end
				crte_pkg::ST_SEC_D: begin
					sec_q <= 32'(days_q * 32'(crte_pkg::SEC_DAY));
				end
				crte_pkg::ST_SEC_H: begin
					sec_q <= sec_q + 32'(32'($signed(fields_q[3])) * 32'(crte_pkg::SEC_HOUR));
				end
				crte_pkg::ST_SEC_M: begin
					sec_q <= sec_q + 32'(32'($signed(fields_q[4])) * 32'(crte_pkg::SEC_MIN));
				end
				crte_pkg::ST_SEC_S: begin
					sec_q <= sec_q + 32'($signed(fields_q[5])) - tz_sec;
				end
				default: begin
					sec_q <= sec_q;
				end
			endcase
		end
	end

	// output word, held until the controller loads the next one
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q    <= fields_ok;
			epoch_q <= fields_ok ? sec_q : 32'd0;
		end
	end

	assign status.field_open = (phase_q == crte_pkg::PH_DIGITS);
	assign status.fields_ok  = fields_ok;
	assign time_ok           = ok_q;
	assign epoch_seconds     = epoch_q;

endmodule

// ===== src/crte_checker.sv =====
// Port-level checks for clock_reply_to_epoch, attached with a bind.
// Sees only the top level's ports; no package needed.
module crte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_stall,
	input logic [7:0]  reply_byte,
	input logic        last_byte,
	input logic        result_valid,
	input logic        result_stall,
	input logic        time_ok,
	input logic [31:0] epoch_seconds
);

	// a failed reply reports zero seconds
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !time_ok |-> epoch_seconds == 32'd0)
		else $error("failed result with nonzero epoch");

	// hold off input while the reply is being converted
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && last_byte |=> byte_stall)
		else $error("byte accepted right after last byte");

	// a new result appears only out of the conversion phase
	a_rise_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_stall))
		else $error("result appeared while input was open");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(time_ok) && $stable(epoch_seconds))
		else $error("stalled result changed");

endmodule

bind clock_reply_to_epoch crte_checker u_crte_checker (.*);
